// ===== design/multi_lane_content_hash_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the multi-lane content hash unit
// Concurrent checks sampled on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef MULTI_LANE_CONTENT_HASH_UNIT_MACROS_SVH
`define MULTI_LANE_CONTENT_HASH_UNIT_MACROS_SVH

// same-cycle implication
`define MLCH_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mlch check failed");

// next-cycle implication
`define MLCH_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mlch check failed");

`endif

// ===== design/mlch_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlch_pkg
// Shared types and constants of the multi-lane content hash unit.
// ----------------------------------------------------------------------------
package mlch_pkg;

   localparam int unsigned LANE_COUNT = 8;
   localparam int unsigned LANE_W     = 32;
   localparam int unsigned LANE_IDX_W = $clog2(LANE_COUNT);

   typedef logic [LANE_W-1:0]     lane_word_type;
   typedef logic [LANE_IDX_W-1:0] lane_idx_type;
   typedef lane_word_type         lane_array_type [LANE_COUNT];

   localparam lane_word_type HASH_PRIME = 32'd16777619;

   localparam lane_word_type LANE_SEED [LANE_COUNT] = '{
      32'd2166136261, 32'd2246822519, 32'd3266489917, 32'd668265263,
      32'd374761393,  32'd1274126177, 32'd42595009,   32'd2048419325
   };

   // load request from the top level to the word emitter
   typedef struct packed {
      logic load;
   } emit_ctrl_type;

endpackage

// ===== design/mlch_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlch_lane
// Next value of one hash lane: optional seed reload, then multiply-add.
// ----------------------------------------------------------------------------
module mlch_lane #(
   parameter int unsigned LANE_ID = 0
) (
   input  mlch_pkg::lane_word_type lane_cur,
   input  logic                    first_byte,
   input  logic [7:0]              data_byte,
   output mlch_pkg::lane_word_type lane_next
);
   import mlch_pkg::*;

   lane_word_type base;
   lane_word_type prod;

   assign base      = first_byte ? LANE_SEED[LANE_ID] : lane_cur;
   assign prod      = LANE_W'(base * HASH_PRIME);
   assign lane_next = prod + {24'd0, data_byte} + LANE_W'(LANE_ID);

endmodule

// ===== design/mlch_emit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlch_emit
// Holds a snapshot of the eight lanes and shifts them out one word per item.
// ----------------------------------------------------------------------------
module mlch_emit (
   input  logic                     clock,
   input  logic                     reset,
   input  mlch_pkg::emit_ctrl_type  ctrl,
   input  mlch_pkg::lane_array_type lanes_new,
   output logic                     free,
   output logic                     word_valid,
   input  logic                     word_ready,
   output mlch_pkg::lane_word_type  word,
   output mlch_pkg::lane_idx_type   word_lane,
   output logic                     word_final
);
   import mlch_pkg::*;

   localparam lane_idx_type LAST_LANE = LANE_IDX_W'(LANE_COUNT - 1);

   lane_word_type words_ff [LANE_COUNT];
   lane_idx_type  cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          pop;

   assign pop        = busy_ff & word_ready;
   assign word_final = (cnt_ff == LAST_LANE);
   assign free       = ~busy_ff | (pop & word_final);
   assign word_valid = busy_ff;
   assign word       = words_ff[0];
   assign word_lane  = cnt_ff;

   always_comb begin
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (ctrl.load) begin
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (pop) begin
         cnt_in  = cnt_ff + 1'b1;
         busy_in = ~word_final;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   // payload: load snapshot or advance the shift line
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         words_ff <= lanes_new;
      end else if (pop) begin
         for (int k = 0; k < LANE_COUNT - 1; k++) begin
            words_ff[k] <= words_ff[k+1];
         end
      end
   end

endmodule

// ===== design/multi_lane_content_hash_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_lane_content_hash_unit
// Eight-lane multiplicative hash over a byte stream, 256-bit identity out.
// ----------------------------------------------------------------------------
// One byte is absorbed per cycle: each of the eight 32-bit lanes takes
// lane*16777619 + byte + lane number in a single constant multiply-add.
// tuser marks the first byte of a message (seeds reloaded before it), tlast
// the last one. After a last byte the eight lane words come out lane 0
// first, one per cycle while rsp_tready is high, with tlast on lane 7.
// Bytes keep flowing during that output; a further last byte waits until
// the final word of the previous identity is taken, so the sustained rate
// is one byte per cycle save where a last byte meets an identity still going out.
module multi_lane_content_hash_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] first_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] identity_word, [34:32] lane_number, zeros
   output logic        rsp_tlast    // final_word
);
   import mlch_pkg::*;

   lane_word_type  lanes_ff [LANE_COUNT];
   lane_array_type lanes_in;
   emit_ctrl_type  ctrl;
   logic           accept;
   logic           emit_free;
   lane_word_type  word;
   lane_idx_type   word_lane;

   assign req_tready = ~req_tlast | emit_free;
   assign accept     = req_tvalid & req_tready;
   assign ctrl.load  = accept & req_tlast;

   for (genvar g = 0; g < LANE_COUNT; g++) begin : g_lane
      mlch_lane #(.LANE_ID(g)) u_lane (
         .lane_cur   (lanes_ff[g]),
         .first_byte (req_tuser),
         .data_byte  (req_tdata),
         .lane_next  (lanes_in[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lanes_ff <= LANE_SEED;
      end else if (accept) begin
         lanes_ff <= lanes_in;
      end
   end

   mlch_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .lanes_new  (lanes_in),
      .free       (emit_free),
      .word_valid (rsp_tvalid),
      .word_ready (rsp_tready),
      .word       (word),
      .word_lane  (word_lane),
      .word_final (rsp_tlast)
   );

   assign rsp_tdata = {5'd0, word_lane, word};

endmodule

// ===== design/mlch_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlch_checker
// Port-level checks of the multi-lane content hash unit, bound to the top.
// ----------------------------------------------------------------------------
`include "multi_lane_content_hash_unit_macros.svh"

module mlch_port_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast
);

   logic       req_take;
   logic       rsp_pop;
   logic [2:0] rsp_lane;
   logic [2:0] lane_inc;

   assign req_take = req_tvalid & req_tready;
   assign rsp_pop  = rsp_tvalid & rsp_tready;
   assign rsp_lane = rsp_tdata[34:32];
   assign lane_inc = rsp_lane + 3'd1;

   `MLCH_ASSERT_NXT(a_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `MLCH_ASSERT_NXT(a_start, req_take && req_tlast, rsp_tvalid && rsp_lane == 3'd0)
   `MLCH_ASSERT_IMP(a_final, rsp_tvalid, rsp_tlast == (rsp_lane == 3'd7))
   `MLCH_ASSERT_NXT(a_order, rsp_pop && !rsp_tlast, rsp_tvalid && rsp_lane == $past(lane_inc))
   `MLCH_ASSERT_IMP(a_pad, rsp_tvalid, rsp_tdata[39:35] == 5'd0)

endmodule

bind multi_lane_content_hash_unit mlch_port_checker u_mlch_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// ===== tb/sv/mlch_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlch_checker
// Watches both item channels of the content hash unit, runs its own eight
// lane hash on every accepted byte and compares each identity word that
// leaves the block against the oldest word it has worked out.
// ----------------------------------------------------------------------------
module mlch_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] first_byte
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // [31:0] identity_word, [34:32] lane_number, zeros
   input  logic        rsp_tlast,
   output int          mismatch_count,
   output int          words_pending,
   output int          words_compared
);
   import mlch_pkg::*;

   typedef struct {
      lane_word_type identity_word;
      lane_idx_type  lane_number;
      logic          final_word;
   } identity_word_type;

   lane_array_type    running_lanes;
   identity_word_type identity_queue [$];

   task automatic note_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      $display("[%0t] mismatch on %s: got 0x%08h, wanted 0x%08h", $time, what, got, want);
      mismatch_count++;
   endtask

   function automatic void absorb_byte(input logic [7:0] value, input logic reload,
                                       input logic emit);
      identity_word_type word;
      if (reload) begin
         running_lanes = LANE_SEED;
      end
      for (int k = 0; k < LANE_COUNT; k++) begin
         running_lanes[k] = running_lanes[k] * HASH_PRIME + lane_word_type'(value)
                            + lane_word_type'(k);
      end
      if (emit) begin
         for (int k = 0; k < LANE_COUNT; k++) begin
            word.identity_word = running_lanes[k];
            word.lane_number   = lane_idx_type'(k);
            word.final_word    = (k == LANE_COUNT - 1);
            identity_queue.push_back(word);
         end
      end
   endfunction

   always @(posedge clock) begin : monitor
      identity_word_type want;
      if (reset) begin
         running_lanes = LANE_SEED;
         identity_queue.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            absorb_byte(req_tdata, req_tuser, req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            words_compared++;
            if (identity_queue.size() == 0) begin
               note_mismatch("unexpected word", rsp_tdata[31:0], 32'd0);
            end else begin
               want = identity_queue.pop_front();
               if (rsp_tdata[31:0] !== want.identity_word) begin
                  note_mismatch("identity_word", rsp_tdata[31:0], want.identity_word);
               end
               if (rsp_tdata[34:32] !== want.lane_number) begin
                  note_mismatch("lane_number", 32'(rsp_tdata[34:32]), 32'(want.lane_number));
               end
               if (rsp_tlast !== want.final_word) begin
                  note_mismatch("final_word", 32'(rsp_tlast), 32'(want.final_word));
               end
            end
         end
      end
      words_pending = identity_queue.size();
   end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Byte stream stimulus for the multi-lane content hash unit: a few directed
// messages around seed reload and continuation, then random well-formed
// messages mixed with stray fragments, under random idling on both sides.
// ----------------------------------------------------------------------------
module testbench;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'd0;
   logic        req_tuser  = 1'b0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;

   int          mismatch_count;
   int          words_pending;
   int          words_compared;

   bit          calm          = 1'b0;
   bit          stall_request = 1'b0;
   int          items_sent    = 0;
   int          messages_sent = 0;
   logic [7:0]  message_bytes [$];

   multi_lane_content_hash_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   mlch_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .words_pending  (words_pending),
      .words_compared (words_compared)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #2400000;
      $display("*** FAILED ***");
      $finish;
   end

   // receiver: random back-pressure, one long hold-off on request
   initial begin
      @(negedge clock);
      forever begin
         if (stall_request) begin
            rsp_tready = 1'b0;
            repeat (120) @(negedge clock);
            stall_request = 1'b0;
         end
         rsp_tready = calm || ($urandom_range(99) >= 33);
         @(negedge clock);
      end
   end

   task automatic send_byte(input logic [7:0] value, input bit is_first, input bit is_last);
      while (!calm && $urandom_range(99) < 33) begin
         req_tvalid = 1'b0;
         req_tdata  = 8'($urandom);
         req_tuser  = 1'($urandom);
         req_tlast  = 1'($urandom);
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = value;
      req_tuser  = is_first;
      req_tlast  = is_last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   // send message_bytes, flags on the first and final byte only
   task automatic send_message(input bit mark_first, input bit mark_last);
      int n;
      n = message_bytes.size();
      for (int i = 0; i < n; i++) begin
         send_byte(message_bytes[i], mark_first && (i == 0), mark_last && (i == n - 1));
      end
      messages_sent++;
   endtask

   task automatic build_header(input logic [31:0] w0, input logic [31:0] w1,
                               input logic [31:0] w2, input logic [31:0] w3);
      logic [31:0] words [4];
      words = '{w0, w1, w2, w3};
      message_bytes.delete();
      for (int w = 0; w < 4; w++) begin
         for (int i = 0; i < 4; i++) begin
            message_bytes.push_back(words[w][8*i +: 8]);
         end
      end
   endtask

   initial begin : stimulus
      int msg_index;
      int kind;
      int body_len;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // no first flag since reset: start from the seeds
      message_bytes = '{8'h00, 8'hFF};
      send_message(1'b0, 1'b1);
      // first and last on the same byte
      message_bytes = '{8'h80};
      send_message(1'b1, 1'b1);
      // no first after a last: continue from the emitted lanes
      message_bytes = '{8'h55};
      send_message(1'b0, 1'b1);
      // full header plus a short artifact
      build_header(32'h0000_0000, 32'hFFFF_FFFF, 32'h1234_5678, 32'h8000_0001);
      message_bytes.push_back(8'hA5);
      message_bytes.push_back(8'h7F);
      send_message(1'b1, 1'b1);

      req_tvalid = 1'b0;
      wait (words_pending == 0);
      @(negedge clock);

      msg_index = 0;
      while (items_sent < 310) begin
         msg_index++;
         calm = (msg_index >= 4 && msg_index < 8);
         if (msg_index == 10) begin
            stall_request = 1'b1;
         end
         if (msg_index == 14) begin
            req_tvalid = 1'b0;
            wait (words_pending == 0);
            @(negedge clock);
         end
         kind = $urandom_range(9);
         if (kind < 7) begin
            build_header($urandom, $urandom, $urandom, $urandom);
            body_len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
            repeat (body_len) message_bytes.push_back(8'($urandom));
            send_message(1'b1, 1'b1);
         end else begin
            // stray fragment: flags fall anywhere
            message_bytes.delete();
            repeat ($urandom_range(1, 5)) message_bytes.push_back(8'($urandom));
            send_message(1'($urandom), 1'($urandom));
         end
      end
      calm = 1'b0;
      req_tvalid = 1'b0;

      wait (words_pending == 0);
      repeat (16) @(posedge clock);
      $display("Run covered %0d bytes in %0d messages and fragments,", items_sent,
               messages_sent);
      $display("with %0d identity words compared under random back-pressure.",
               words_compared);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
